### rtl/brle_pkg.sv
package brle_pkg;

    // Width of the internal run counter and of the run length field
    localparam int COUNT_W = 16;
    localparam int RUN_W   = 16;

    // Depth of the word queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [RUN_W-1:0]   RUN_MAX   = '1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } pixel_word_t;

    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic             run_of_ones;
        logic             last_run;
    } run_word_t;

    // One classified byte: pixels, value changes (bit 7 against the open run,
    // bit i<7 against bit i+1), length of the first run it closes, length of
    // the run left open at its end, and the final-byte mark
    typedef struct packed {
        logic [7:0]       pixels;
        logic [7:0]       edges;
        logic [RUN_W-1:0] first_len;
        logic [RUN_W-1:0] tail_len;
        logic             last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

### rtl/brle_front.sv
module brle_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pixel_valid,
    input  brle_pkg::pixel_word_t   pixel_word,
    output logic                    pixel_stall,
    input  brle_pkg::q_status_t     q_status,
    output logic                    push,
    output brle_pkg::entry_t        entry
);
    import brle_pkg::*;

    logic               value_reg, value_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [7:0]         edges;
    logic [2:0]         hi_pos;
    logic [2:0]         lo_pos;
    logic [2:0]         lead;
    logic [COUNT_W-1:0] first_count;
    logic [COUNT_W-1:0] tail_count;
    logic               accept;

    // saturating add of the open count and a small step
    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] c,
                                                   input logic [3:0] step);
        logic [COUNT_W:0] s;
        s = {1'b0, c} + (COUNT_W+1)'(step);
        if (s > {1'b0, COUNT_MAX})
            return COUNT_MAX;
        else
            return s[COUNT_W-1:0];
    endfunction

    // clip the counter to the run length field
    function automatic logic [RUN_W-1:0] clip_len(input logic [COUNT_W-1:0] c);
        logic [COUNT_W+RUN_W-1:0] c_ext;
        c_ext = (COUNT_W+RUN_W)'(c);
        if (c_ext > (COUNT_W+RUN_W)'(RUN_MAX))
            return RUN_MAX;
        else
            return c_ext[RUN_W-1:0];
    endfunction

    // value changes inside the byte and against the open run
    always_comb
    begin
        edges[7] = pixel_word.data_byte[7] ^ value_reg;
        for (int i = 0; i < 7; i++)
        begin
            edges[i] = pixel_word.data_byte[i] ^ pixel_word.data_byte[i+1];
        end
    end

    // first and last change positions
    always_comb
    begin
        hi_pos = 3'd0;
        lo_pos = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (edges[i])
                hi_pos = 3'(i);
        end
        for (int i = 7; i >= 0; i--)
        begin
            if (edges[i])
                lo_pos = 3'(i);
        end
    end

    always_comb
    begin
        lead        = 3'd7 - hi_pos;
        first_count = sat_add(count_reg, {1'b0, lead});
        if (|edges)
            tail_count = COUNT_W'(lo_pos) + COUNT_W'(1);
        else
            tail_count = sat_add(count_reg, 4'd8);
    end

    assign accept      = pixel_valid && !q_status.full;
    assign pixel_stall = q_status.full;
    assign push        = accept && ((|edges) || pixel_word.last_byte);

    always_comb
    begin
        entry.pixels    = pixel_word.data_byte;
        entry.edges     = edges;
        entry.first_len = clip_len(first_count);
        entry.tail_len  = clip_len(tail_count);
        entry.last      = pixel_word.last_byte;
    end

    // run state; the final byte returns it to reset
    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (pixel_word.last_byte)
            begin
                value_next = 1'b1;
                count_next = '0;
            end
            else
            begin
                value_next = pixel_word.data_byte[0];
                count_next = tail_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= 1'b1;
            count_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/brle_queue.sv
module brle_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  brle_pkg::entry_t    entry,
    input  logic                pop,
    output brle_pkg::q_status_t q_status,
    output brle_pkg::entry_t    head
);
    import brle_pkg::*;

    entry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1))
            return '0;
        else
            return p + QPTR_W'(1);
    endfunction

    assign q_status.full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_status.not_empty = (cnt_reg != '0);
    assign head               = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= entry;
    end

endmodule

### rtl/brle_back.sv
module brle_back (
    input  logic                clk,
    input  logic                rst_n,
    input  brle_pkg::q_status_t q_status,
    input  brle_pkg::entry_t    head,
    output logic                pop,
    output logic                run_valid,
    input  logic                run_stall,
    output brle_pkg::run_word_t run_word
);
    import brle_pkg::*;

    logic        first_reg, first_next;
    logic [7:0]  rem_reg, rem_next;
    logic [2:0]  prev_reg, prev_next;
    logic        out_valid_reg, out_valid_next;
    run_word_t   out_word_reg, out_word_next;

    logic [7:0]  rem;
    logic [2:0]  pos;
    logic        done;
    logic        load;

    // changes still to be turned into runs for the head word
    assign rem = first_reg ? head.edges : rem_reg;

    always_comb
    begin
        pos = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (rem[i])
                pos = 3'(i);
        end
    end

    assign load = q_status.not_empty && (!out_valid_reg || !run_stall);

    // next run of the head word
    always_comb
    begin
        rem_next  = rem;
        prev_next = prev_reg;
        if (|rem)
        begin
            if (first_reg)
                out_word_next.run_length = head.first_len;
            else
                out_word_next.run_length = RUN_W'(prev_reg - pos);
            out_word_next.run_of_ones = ~head.pixels[pos];
            out_word_next.last_run    = 1'b0;
            rem_next                  = rem & ~(8'b1 << pos);
            prev_next                 = pos;
            done                      = (rem_next == '0) && !head.last;
        end
        else
        begin
            out_word_next.run_length  = head.tail_len;
            out_word_next.run_of_ones = head.pixels[0];
            out_word_next.last_run    = 1'b1;
            done                      = 1'b1;
        end
    end

    assign pop = load && done;

    always_comb
    begin
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            first_next     = done;
            out_valid_next = 1'b1;
        end
        else if (!run_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output word and walk position
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_word_reg <= out_word_next;
            rem_reg      <= rem_next;
            prev_reg     <= prev_next;
        end
    end

    assign run_valid = out_valid_reg;
    assign run_word  = out_word_reg;

endmodule

### rtl/bit_run_length_encoder.sv
// Binary run-length encoder for packed black-and-white pixel bytes.
// Pixel channel: pixel_valid / pixel_stall / pixel_word carry one byte per
// word, bit 7 first, with last_byte marking the final byte of an image.
// Run channel: run_valid / run_stall / run_word carry one finished run per
// word: its length (saturating), whether it counted ones, and the final mark.
// Runs alternate starting with ones; an image opening with a zero gives a
// ones run of length zero first.
// The first run of a byte passes through the queue storage and then the
// output word register. The front classifies a byte combinationally and
// takes one byte every cycle while the four-word queue has room; the back
// emits one run per cycle while the receiver does not stall, so a byte
// holds the back until the runs it closes are out; sustained rate is
// set by the total run count. Bytes closing no run never enter the queue.
// Reset clears the run state (current value one, count zero), empties the
// queue and drops any pending run word. While the receiver stalls, the run
// word holds; the queue keeps filling and pixel_stall rises when it is full.
module bit_run_length_encoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  brle_pkg::pixel_word_t pixel_word,
    output logic                  run_valid,
    input  logic                  run_stall,
    output brle_pkg::run_word_t   run_word
);
    import brle_pkg::*;

    q_status_t q_status;
    entry_t    entry;
    entry_t    head;
    logic      push;
    logic      pop;

    brle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_word  (pixel_word),
        .pixel_stall (pixel_stall),
        .q_status    (q_status),
        .push        (push),
        .entry       (entry)
    );

    brle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .entry    (entry),
        .pop      (pop),
        .q_status (q_status),
        .head     (head)
    );

    brle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .run_valid (run_valid),
        .run_stall (run_stall),
        .run_word  (run_word)
    );

endmodule

### rtl/brle_checker.sv
module brle_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pixel_valid,
    input logic                  pixel_stall,
    input brle_pkg::pixel_word_t pixel_word,
    input logic                  run_valid,
    input logic                  run_stall,
    input brle_pkg::run_word_t   run_word
);
    import brle_pkg::*;

    // a stalled pixel word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_word))
        else $error("pixel word changed under stall");

    // a stalled run word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run_stall |=> run_valid && $stable(run_word))
        else $error("run word changed under stall");

    // an empty run must be a ones run; only the opening run of an image can be empty
    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && (run_word.run_length == '0) |-> run_word.run_of_ones)
        else $error("empty run of zeros");

    // the final run always covers at least one pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run_word.last_run |-> run_word.run_length != '0)
        else $error("empty final run");

    // nothing is offered while reset is held
    assert property (@(posedge clk) !rst_n |-> !run_valid)
        else $error("run word offered in reset");

endmodule

bind bit_run_length_encoder brle_checker u_brle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_word  (pixel_word),
    .run_valid   (run_valid),
    .run_stall   (run_stall),
    .run_word    (run_word)
);

### tb/sv/tb.sv
module tb;

    import brle_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 40;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b1;
    logic        pixel_valid = 1'b0;
    logic        pixel_stall;
    pixel_word_t pixel_word  = '0;
    logic        run_valid;
    logic        run_stall   = 1'b0;
    run_word_t   run_word;

    // Words waiting to be driven, and runs the encoder still owes us
    pixel_word_t bytes_to_send[$];
    run_word_t   runs_due[$];

    // Shadow copy of the encoder's run state
    logic             open_value = 1'b1;
    logic [RUN_W-1:0] open_count = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int cycles = 0;

    bit_run_length_encoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_word  (pixel_word),
        .run_valid   (run_valid),
        .run_stall   (run_stall),
        .run_word    (run_word)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    endtask

    // Walk the pixels of one accepted word, queueing every run it closes
    task automatic encode_byte(input pixel_word_t w);
        int        i;
        run_word_t r;
        for (i = 7; i >= 0; i--)
        begin
            if (w.data_byte[i] == open_value)
            begin
                if (open_count != '1)
                    open_count++;
            end
            else
            begin
                r.run_length  = open_count;
                r.run_of_ones = open_value;
                r.last_run    = 1'b0;
                runs_due.push_back(r);
                open_value = w.data_byte[i];
                open_count = RUN_W'(1);
            end
        end
        // final word of an image closes the open run and starts afresh
        if (w.last_byte)
        begin
            r.run_length  = open_count;
            r.run_of_ones = open_value;
            r.last_run    = 1'b1;
            runs_due.push_back(r);
            open_value = 1'b1;
            open_count = '0;
        end
    endtask

    task automatic add_byte(input logic [7:0] pixels, input logic last);
        pixel_word_t w;
        w.data_byte = pixels;
        w.last_byte = last;
        bytes_to_send.push_back(w);
    endtask

    function automatic logic [7:0] random_pixels();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0, 1: b = 8'($urandom);
            2:    b = 8'h00;
            3:    b = 8'hFF;
            4:    b = $urandom_range(0, 1) ? 8'hAA : 8'h55;
            default:
            begin
                b = 8'hFF >> $urandom_range(1, 7);
                if ($urandom_range(0, 1))
                    b = ~b;
            end
        endcase
        return b;
    endfunction

    // Mostly whole images with random content; some long flat images and
    // some left unterminated so the open run carries into the next one
    task automatic add_images(input int quota);
        int         sent;
        int         len;
        int         k;
        bit         flat;
        bit         closed;
        logic [7:0] fill;
        sent = 0;
        while (sent < quota)
        begin
            flat   = ($urandom_range(0, 9) == 0);
            closed = ($urandom_range(0, 5) != 0);
            len    = flat ? $urandom_range(20, 40) : $urandom_range(1, 8);
            fill   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            for (k = 0; k < len; k++)
            begin
                if (flat && $urandom_range(0, 7) != 0)
                    add_byte(fill, closed && (k == len - 1));
                else
                    add_byte(random_pixels(), closed && (k == len - 1));
            end
            sent += len;
        end
    endtask

    // Pixel side driver: predict on acceptance, then offer the next word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel_word  <= '0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
                encode_byte(pixel_word);
            if (!(pixel_valid && pixel_stall))
            begin
                if (bytes_to_send.size() != 0 && $urandom_range(1, 100) > send_idle_pct)
                begin
                    pixel_valid <= 1'b1;
                    pixel_word  <= bytes_to_send.pop_front();
                end
                else
                    pixel_valid <= 1'b0;
            end
        end
    end

    // Run side monitor: check each accepted word against the oldest due run
    always @(posedge clk or negedge rst_n)
    begin : run_monitor
        run_word_t due;
        if (!rst_n)
            run_stall <= 1'b0;
        else
        begin
            if (run_valid && !run_stall)
            begin
                if (runs_due.size() == 0)
                    flag_mismatch("unexpected run word, length", run_word.run_length, -1);
                else
                begin
                    due = runs_due.pop_front();
                    if (run_word.run_length !== due.run_length)
                        flag_mismatch("run_length", run_word.run_length, due.run_length);
                    if (run_word.run_of_ones !== due.run_of_ones)
                        flag_mismatch("run_of_ones", run_word.run_of_ones, due.run_of_ones);
                    if (run_word.last_run !== due.last_run)
                        flag_mismatch("last_run", run_word.last_run, due.last_run);
                end
            end
            run_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        #1 rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase

            if (phase == 0)
            begin
                // image opening with zero, all ones, most runs per word
                add_byte(8'h00, 1'b1);
                add_byte(8'hFF, 1'b1);
                add_byte(8'h55, 1'b1);
                add_byte(8'hAA, 1'b0);
                add_byte(8'h55, 1'b1);
                // runs spanning words
                add_byte(8'h0F, 1'b0);
                add_byte(8'hF0, 1'b0);
                add_byte(8'hFF, 1'b0);
                add_byte(8'h01, 1'b1);
                add_byte(8'h80, 1'b1);
                add_byte(8'h7F, 1'b0);
                add_byte(8'hFE, 1'b1);
            end

            add_images(58);
            if (phase == 3)
                add_byte(random_pixels(), 1'b1);

            do
                @(negedge clk);
            while (bytes_to_send.size() != 0 || pixel_valid || runs_due.size() != 0);
        end

        // let any stray run words show up
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
